// ----- design/prbs_pkg.sv -----
// ----------------------------------------------------------------------------
// prbs_pkg
// Shared types, constants and helpers of the peak / RMS block summary.
// ----------------------------------------------------------------------------
package prbs_pkg;

   localparam int SAMPLE_W     = 16;
   localparam int MAG_W        = 17;
   localparam int SQR_W        = 31;
   localparam int LEVEL_W      = 8;
   localparam int ODD_W        = 9;
   localparam int ODD_SQ_W     = 18;
   localparam int RMS_SCALE_W  = 18;
   localparam int RMS_FRAC     = 30;
   localparam int SHIFT_REST   = RMS_FRAC - RMS_SCALE_W;

   // 4 * 255^2, the scale of the rms test
   localparam logic [RMS_SCALE_W-1:0] RMS_SCALE = 18'd260100;
   localparam logic [LEVEL_W-1:0]     LEVEL_MAX = 8'd255;
   localparam logic [24:0]            PEAK_HALF = 25'd16384;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_START,
      ST_RMS,
      ST_HOLD
   } ctl_state_type;

   typedef enum logic [2:0] {
      RS_IDLE,
      RS_MUL,
      RS_SQUARE,
      RS_CHECK,
      RS_DONE
   } rms_state_type;

   typedef struct packed {
      logic capture;
      logic update;
   } acc_ctl_type;

   typedef struct packed {
      logic emit;
   } acc_stat_type;

   typedef struct packed {
      logic start;
   } rms_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } rms_stat_type;

   // round(|x| * 255) with half up, saturated
   function automatic logic [LEVEL_W-1:0] peak_of(input logic [MAG_W-1:0] mag);
      logic [24:0] t;
      logic [9:0]  q;
      t = {mag, 8'b0} - 25'(mag) + PEAK_HALF;
      q = t[24:15];
      peak_of = (q > 10'(LEVEL_MAX)) ? LEVEL_MAX : q[LEVEL_W-1:0];
   endfunction

endpackage

// ----- design/prbs_req_if.sv -----
// ----------------------------------------------------------------------------
// prbs_req_if
// Sample channel: valid / ready handshake with sample, channel and last.
// ----------------------------------------------------------------------------
interface prbs_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [prbs_pkg::SAMPLE_W-1:0] sample;
   logic                                 channel;
   logic                                 last;

   modport source (output valid, sample, channel, last, input ready);
   modport sink   (input valid, sample, channel, last, output ready);
endinterface

// ----- design/prbs_rsp_if.sv -----
// ----------------------------------------------------------------------------
// prbs_rsp_if
// Summary channel: valid / ready handshake with one overview entry.
// ----------------------------------------------------------------------------
interface prbs_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            out_channel;
   logic [prbs_pkg::LEVEL_W-1:0]    peak_level;
   logic [prbs_pkg::LEVEL_W-1:0]    rms_level;

   modport source (output valid, out_channel, peak_level, rms_level, input ready);
   modport sink   (input valid, out_channel, peak_level, rms_level, output ready);
endinterface

// ----- design/prbs_accum.sv -----
// ----------------------------------------------------------------------------
// prbs_accum
// Per-channel block state: square sum, block peak and fill count.
// ----------------------------------------------------------------------------
module prbs_accum #(
   parameter int BLOCK_LEN = 128,
   parameter int CHANNELS  = 2,
   parameter int SUM_W     = prbs_pkg::SQR_W + $clog2(BLOCK_LEN)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  prbs_pkg::acc_ctl_type                ctl,
   input  logic signed [prbs_pkg::SAMPLE_W-1:0] sample,
   input  logic                                 channel,
   input  logic                                 last,
   output prbs_pkg::acc_stat_type               stat,
   output logic [SUM_W-1:0]                     blk_sum,
   output logic [prbs_pkg::LEVEL_W-1:0]         blk_peak,
   output logic                                 blk_ch
);

   localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int FILL_W = $clog2(BLOCK_LEN + 1);

   logic [prbs_pkg::MAG_W-1:0]     mag_in;
   logic [2*prbs_pkg::MAG_W-1:0]   sq_full;
   logic [prbs_pkg::SQR_W-1:0]     sq_ff;
   logic [prbs_pkg::LEVEL_W-1:0]   pk_ff;
   logic                           ch_ff;
   logic                           last_ff;

   logic [SUM_W-1:0]               sum_ff  [CHANNELS];
   logic [prbs_pkg::LEVEL_W-1:0]   peak_ff [CHANNELS];
   logic [FILL_W-1:0]              fill_ff [CHANNELS];

   logic [IDX_W-1:0]               idx;
   logic                           in_range;
   logic [FILL_W-1:0]              fill_next;
   logic [SUM_W-1:0]               sum_next;
   logic [prbs_pkg::LEVEL_W-1:0]   peak_next;

   logic [SUM_W-1:0]               blk_sum_ff;
   logic [prbs_pkg::LEVEL_W-1:0]   blk_peak_ff;
   logic                           blk_ch_ff;

   // two's complement magnitude, 0..32768
   always_comb begin
      if (sample[prbs_pkg::SAMPLE_W-1]) begin
         mag_in = prbs_pkg::MAG_W'(0) - {1'b1, sample};
      end else begin
         mag_in = {1'b0, sample};
      end
   end

   assign sq_full = mag_in * mag_in;

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         sq_ff   <= sq_full[prbs_pkg::SQR_W-1:0];
         pk_ff   <= prbs_pkg::peak_of(mag_in);
         ch_ff   <= channel;
         last_ff <= last;
      end
   end

   assign idx       = IDX_W'(ch_ff);
   assign in_range  = (32'(ch_ff) < CHANNELS);
   assign fill_next = fill_ff[idx] + FILL_W'(1);
   assign sum_next  = sum_ff[idx] + SUM_W'(sq_ff);
   assign peak_next = (pk_ff > peak_ff[idx]) ? pk_ff : peak_ff[idx];

   assign stat.emit = in_range && ((fill_next >= FILL_W'(BLOCK_LEN)) || last_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            sum_ff[i]  <= '0;
            peak_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
      end else if (ctl.update && in_range) begin
         if (stat.emit) begin
            sum_ff[idx]  <= '0;
            peak_ff[idx] <= '0;
            fill_ff[idx] <= '0;
         end else begin
            sum_ff[idx]  <= sum_next;
            peak_ff[idx] <= peak_next;
            fill_ff[idx] <= fill_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.update && stat.emit) begin
         blk_sum_ff  <= sum_next;
         blk_peak_ff <= peak_next;
         blk_ch_ff   <= ch_ff;
      end
   end

   assign blk_sum  = blk_sum_ff;
   assign blk_peak = blk_peak_ff;
   assign blk_ch   = blk_ch_ff;

endmodule

// ----- design/prbs_rms.sv -----
// ----------------------------------------------------------------------------
// prbs_rms
// Iterative rms level: serial shift-add scaling of the square sum, then a
// bitwise search for the largest level whose half-up boundary still fits.
// ----------------------------------------------------------------------------
module prbs_rms #(
   parameter int BLOCK_LEN = 128,
   parameter int SUM_W     = prbs_pkg::SQR_W + $clog2(BLOCK_LEN)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  prbs_pkg::rms_ctl_type         ctl,
   input  logic [SUM_W-1:0]              sum,
   output prbs_pkg::rms_stat_type        stat,
   output logic [prbs_pkg::LEVEL_W-1:0]  level
);

   localparam int CNT_W = $clog2(prbs_pkg::RMS_SCALE_W);
   localparam int BIT_W = $clog2(prbs_pkg::LEVEL_W);
   localparam int Q_W   = SUM_W - prbs_pkg::SHIFT_REST;
   localparam int BL_W  = $clog2(BLOCK_LEN + 1);
   localparam int LHS_W = prbs_pkg::ODD_SQ_W + BL_W;
   localparam int CMP_W = (LHS_W > Q_W) ? LHS_W : Q_W;

   prbs_pkg::rms_state_type state_ff, state_in;

   logic [SUM_W-1:0]                 sum_ff;
   logic [SUM_W-1:0]                 acc_ff;
   logic [CNT_W-1:0]                 cnt_ff;
   logic [prbs_pkg::LEVEL_W-1:0]     r_ff;
   logic [BIT_W-1:0]                 bit_ff;
   logic [prbs_pkg::ODD_SQ_W-1:0]    osq_ff;

   logic [SUM_W-1:0]                 addend;
   logic [SUM_W:0]                   acc_sum;
   logic                             mul_last;
   logic [Q_W-1:0]                   q;
   logic [prbs_pkg::LEVEL_W-1:0]     cand;
   logic [prbs_pkg::ODD_W-1:0]       odd;
   logic [LHS_W-1:0]                 lhs;
   logic                             fits;

   // acc keeps floor(sum * scale_bits_so_far / 2^steps), always below sum
   assign addend   = prbs_pkg::RMS_SCALE[cnt_ff] ? sum_ff : '0;
   assign acc_sum  = {1'b0, acc_ff} + {1'b0, addend};
   assign mul_last = (cnt_ff == CNT_W'(prbs_pkg::RMS_SCALE_W - 1));
   assign q        = acc_ff[SUM_W-1:prbs_pkg::SHIFT_REST];

   assign cand = r_ff | (prbs_pkg::LEVEL_W'(1) << bit_ff);
   assign odd  = {cand, 1'b0} - prbs_pkg::ODD_W'(1);
   assign lhs  = LHS_W'(osq_ff) * LHS_W'(BLOCK_LEN);
   assign fits = (CMP_W'(lhs) <= CMP_W'(q));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         prbs_pkg::RS_IDLE: begin
            if (ctl.start) begin
               state_in = prbs_pkg::RS_MUL;
            end
         end
         prbs_pkg::RS_MUL: begin
            if (mul_last) begin
               state_in = prbs_pkg::RS_SQUARE;
            end
         end
         prbs_pkg::RS_SQUARE: begin
            state_in = prbs_pkg::RS_CHECK;
         end
         prbs_pkg::RS_CHECK: begin
            if (bit_ff == '0) begin
               state_in = prbs_pkg::RS_DONE;
            end else begin
               state_in = prbs_pkg::RS_SQUARE;
            end
         end
         prbs_pkg::RS_DONE: begin
            state_in = prbs_pkg::RS_IDLE;
         end
         default: begin
            state_in = prbs_pkg::RS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= prbs_pkg::RS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         prbs_pkg::RS_IDLE: begin
            if (ctl.start) begin
               sum_ff <= sum;
               acc_ff <= '0;
               cnt_ff <= '0;
               r_ff   <= '0;
               bit_ff <= BIT_W'(prbs_pkg::LEVEL_W - 1);
            end
         end
         prbs_pkg::RS_MUL: begin
            acc_ff <= acc_sum[SUM_W:1];
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         prbs_pkg::RS_SQUARE: begin
            osq_ff <= odd * odd;
         end
         prbs_pkg::RS_CHECK: begin
            if (fits) begin
               r_ff <= cand;
            end
            bit_ff <= bit_ff - BIT_W'(1);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      stat.busy = (state_ff != prbs_pkg::RS_IDLE);
      stat.done = (state_ff == prbs_pkg::RS_DONE);
      level     = r_ff;
   end

endmodule

// ----- design/peak_rms_block_summary_top.sv -----
// ----------------------------------------------------------------------------
// peak_rms_block_summary_top
// Per-channel peak and rms overview of a tagged audio sample stream.
// ----------------------------------------------------------------------------
// A sample that does not close a block passes ST_ACCUM, then ready returns.
// A sample that closes a block also passes ST_START, ST_RMS (18 shift-add
// steps, then 8 search bits of a square and a check each) and ST_HOLD; the
// entry then sits in the output register while the next sample is accepted.
// Synchronous active-high reset clears all channel state and the sequencer.
// ----------------------------------------------------------------------------
module peak_rms_block_summary_top #(
   parameter int BLOCK_LEN = 128,
   parameter int CHANNELS  = 2
) (
   input  logic       clock,
   input  logic       reset,
   prbs_req_if.sink   req_chan,
   prbs_rsp_if.source rsp_chan
);

   localparam int SUM_W = prbs_pkg::SQR_W + $clog2(BLOCK_LEN);

   prbs_pkg::ctl_state_type state_ff, state_in;

   prbs_pkg::acc_ctl_type   acc_ctl;
   prbs_pkg::acc_stat_type  acc_stat;
   prbs_pkg::rms_ctl_type   rms_ctl;
   prbs_pkg::rms_stat_type  rms_stat;

   logic [SUM_W-1:0]                blk_sum;
   logic [prbs_pkg::LEVEL_W-1:0]    blk_peak;
   logic                            blk_ch;
   logic [prbs_pkg::LEVEL_W-1:0]    rms_level;

   logic                            req_take;
   logic                            out_free;
   logic                            out_load;
   logic                            out_valid_ff;
   logic                            out_ch_ff;
   logic [prbs_pkg::LEVEL_W-1:0]    out_peak_ff;
   logic [prbs_pkg::LEVEL_W-1:0]    out_rms_ff;

   prbs_accum #(
      .BLOCK_LEN (BLOCK_LEN),
      .CHANNELS  (CHANNELS),
      .SUM_W     (SUM_W)
   ) u_accum (
      .clock    (clock),
      .reset    (reset),
      .ctl      (acc_ctl),
      .sample   (req_chan.sample),
      .channel  (req_chan.channel),
      .last     (req_chan.last),
      .stat     (acc_stat),
      .blk_sum  (blk_sum),
      .blk_peak (blk_peak),
      .blk_ch   (blk_ch)
   );

   prbs_rms #(
      .BLOCK_LEN (BLOCK_LEN),
      .SUM_W     (SUM_W)
   ) u_rms (
      .clock (clock),
      .reset (reset),
      .ctl   (rms_ctl),
      .sum   (blk_sum),
      .stat  (rms_stat),
      .level (rms_level)
   );

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign req_take = req_chan.valid && req_chan.ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         prbs_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = prbs_pkg::ST_ACCUM;
            end
         end
         prbs_pkg::ST_ACCUM: begin
            if (acc_stat.emit) begin
               state_in = prbs_pkg::ST_START;
            end else begin
               state_in = prbs_pkg::ST_IDLE;
            end
         end
         prbs_pkg::ST_START: begin
            state_in = prbs_pkg::ST_RMS;
         end
         prbs_pkg::ST_RMS: begin
            if (rms_stat.done) begin
               state_in = prbs_pkg::ST_HOLD;
            end
         end
         prbs_pkg::ST_HOLD: begin
            if (out_free) begin
               state_in = prbs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = prbs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= prbs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      req_chan.ready  = (state_ff == prbs_pkg::ST_IDLE);
      acc_ctl.capture = req_take;
      acc_ctl.update  = (state_ff == prbs_pkg::ST_ACCUM);
      rms_ctl.start   = (state_ff == prbs_pkg::ST_START);
      out_load        = (state_ff == prbs_pkg::ST_HOLD) && out_free;
   end

   // output register, so a finished entry can wait while samples keep coming
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ch_ff   <= blk_ch;
         out_peak_ff <= blk_peak;
         out_rms_ff  <= rms_level;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.out_channel = out_ch_ff;
   assign rsp_chan.peak_level  = out_peak_ff;
   assign rsp_chan.rms_level   = out_rms_ff;

   a_busy_after_take: assert property (
      @(posedge clock) disable iff (reset)
      req_take |=> !req_chan.ready
   ) else $error("sample taken while previous one still in work");

   a_rms_starts: assert property (
      @(posedge clock) disable iff (reset)
      (state_ff == prbs_pkg::ST_START) |=> rms_stat.busy
   ) else $error("rms unit did not start");

   a_done_in_rms: assert property (
      @(posedge clock) disable iff (reset)
      rms_stat.done |-> (state_ff == prbs_pkg::ST_RMS)
   ) else $error("rms result arrived outside rms wait");

   a_hold_keeps_entry: assert property (
      @(posedge clock) disable iff (reset)
      ((state_ff == prbs_pkg::ST_HOLD) && !out_free) |=> (state_ff == prbs_pkg::ST_HOLD)
   ) else $error("pending entry dropped");

endmodule
